FILE: design/cgkl_pkg.sv
// Shared types and constants for the color ramp keyframe block.
// Used by the controller, the datapath and the top level; no dependencies.
package cgkl_pkg;

    localparam int MAX_KEYS = 8;
    localparam int IDX_W    = $clog2(MAX_KEYS);
    localparam int CNT_W    = $clog2(MAX_KEYS + 1);
    localparam int DIV_W    = 16;

    localparam logic [15:0] POS_ONE = 16'h8000;

    localparam logic [1:0] OP_CLEAR  = 2'd0;
    localparam logic [1:0] OP_APPEND = 2'd1;
    localparam logic [1:0] OP_SAMPLE = 2'd2;
    localparam logic [1:0] OP_RSVD   = 2'd3;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_MALFORMED = 2'd1;
    localparam logic [1:0] ST_FULL      = 2'd2;

    typedef struct packed {
        logic accept;
        logic scan;
        logic setup;
        logic mul;
        logic div_init;
        logic div_step;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic sample_go;
        logic scan_hit;
        logic scan_last;
        logic have_both;
        logic div_last;
        logic ch_last;
    } t_sts;

endpackage

FILE: design/cgkl_ctrl.sv
// Sequencer for the color ramp block: steps scan, setup, multiply and divide.
// Depends on cgkl_pkg for the command and status structs.
module cgkl_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  logic          i_out_stall,
    input  cgkl_pkg::t_sts i_sts,
    output cgkl_pkg::t_cmd o_cmd,
    output logic          o_in_stall,
    output logic          o_out_valid
);

    typedef enum logic [2:0] {
        S_IDLE, S_SCAN, S_SETUP, S_MUL, S_DINIT, S_DIV, S_DONE
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   acc, load;

    assign acc  = (r_state == S_IDLE) && i_in_valid;
    assign load = (r_state == S_DONE) && (!r_out_valid || !i_out_stall);

    always_comb begin
        o_cmd          = '0;
        o_cmd.accept   = acc;
        o_cmd.scan     = (r_state == S_SCAN);
        o_cmd.setup    = (r_state == S_SETUP);
        o_cmd.mul      = (r_state == S_MUL);
        o_cmd.div_init = (r_state == S_DINIT);
        o_cmd.div_step = (r_state == S_DIV);
        o_cmd.out_load = load;
    end

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid;
        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = i_sts.sample_go ? S_SCAN : S_DONE;
                end
            end
            S_SCAN: begin
                if (i_sts.scan_hit) begin
                    n_state = S_DONE;
                end else if (i_sts.scan_last) begin
                    n_state = S_SETUP;
                end
            end
            S_SETUP: n_state = i_sts.have_both ? S_MUL : S_DONE;
            S_MUL:   n_state = S_DINIT;
            S_DINIT: n_state = S_DIV;
            S_DIV: begin
                if (i_sts.div_last) begin
                    n_state = i_sts.ch_last ? S_DONE : S_MUL;
                end
            end
            S_DONE: begin
                if (load) begin
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

FILE: design/cgkl_dp.sv
// Datapath for the color ramp block: key table, scan, weights, products,
// restoring divider and result register. Depends on cgkl_pkg.
module cgkl_dp (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  cgkl_pkg::t_cmd i_cmd,
    input  logic [1:0]    i_opcode,
    input  logic [15:0]   i_position,
    input  logic [15:0]   i_key_red,
    input  logic [15:0]   i_key_green,
    input  logic [15:0]   i_key_blue,
    output cgkl_pkg::t_sts o_sts,
    output logic [15:0]   o_out_red,
    output logic [15:0]   o_out_green,
    output logic [15:0]   o_out_blue,
    output logic [1:0]    o_out_status
);

    logic [63:0] r_table [cgkl_pkg::MAX_KEYS];
    logic [cgkl_pkg::CNT_W-1:0] r_key_count, r_idx;
    logic [1:0]  r_zero_cnt, r_one_cnt;
    logic        r_range_fault;
    logic        bounds_valid;

    logic [15:0] r_pos;
    logic        r_have_lo, r_have_hi;
    logic [15:0] r_lo_p, r_hi_p;
    logic [47:0] r_lo_col, r_hi_col;
    logic [15:0] r_wl, r_wh, r_span;
    logic [1:0]  r_ch;
    logic [31:0] r_p0, r_p1;
    logic [15:0] r_rem, r_dq;
    logic [3:0]  r_div_cnt;
    logic [15:0] r_res [3];
    logic [1:0]  r_res_st;

    logic [63:0] ent;
    logic [15:0] ent_p, cl, ch, q_next, rem_next;
    logic [16:0] shifted;
    logic [31:0] psum;
    logic        qbit;

    assign bounds_valid = (r_zero_cnt == 2'd1) && (r_one_cnt == 2'd1) && !r_range_fault;
    assign ent   = r_table[r_idx[cgkl_pkg::IDX_W-1:0]];
    assign ent_p = ent[63:48];

    always_comb begin
        unique case (r_ch)
            2'd0:    begin cl = r_lo_col[47:32]; ch = r_hi_col[47:32]; end
            2'd1:    begin cl = r_lo_col[31:16]; ch = r_hi_col[31:16]; end
            default: begin cl = r_lo_col[15:0];  ch = r_hi_col[15:0];  end
        endcase
    end

    assign psum     = r_p0 + r_p1;
    assign shifted  = {r_rem, r_dq[15]};
    assign qbit     = (shifted >= {1'b0, r_span});
    assign rem_next = qbit ? 16'(shifted - {1'b0, r_span}) : shifted[15:0];
    assign q_next   = {r_dq[14:0], qbit};

    always_comb begin
        o_sts           = '0;
        o_sts.sample_go = (i_opcode == cgkl_pkg::OP_SAMPLE) && bounds_valid;
        o_sts.scan_hit  = (ent_p == r_pos);
        o_sts.scan_last = ((r_idx + 1'b1) == r_key_count);
        o_sts.have_both = r_have_lo && r_have_hi;
        o_sts.div_last  = (r_div_cnt == 4'(cgkl_pkg::DIV_W - 1));
        o_sts.ch_last   = (r_ch == 2'd2);
    end

    // Key table and bookkeeping.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_count   <= '0;
            r_zero_cnt    <= '0;
            r_one_cnt     <= '0;
            r_range_fault <= 1'b0;
        end else if (i_cmd.accept) begin
            if (i_opcode == cgkl_pkg::OP_CLEAR) begin
                r_key_count   <= '0;
                r_zero_cnt    <= '0;
                r_one_cnt     <= '0;
                r_range_fault <= 1'b0;
            end else if (i_opcode == cgkl_pkg::OP_APPEND &&
                         r_key_count < cgkl_pkg::CNT_W'(cgkl_pkg::MAX_KEYS)) begin
                r_key_count <= r_key_count + 1'b1;
                if (i_position == 16'd0 && r_zero_cnt < 2'd2) begin
                    r_zero_cnt <= r_zero_cnt + 1'b1;
                end
                if (i_position == cgkl_pkg::POS_ONE && r_one_cnt < 2'd2) begin
                    r_one_cnt <= r_one_cnt + 1'b1;
                end
                if (i_position > cgkl_pkg::POS_ONE) begin
                    r_range_fault <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept && i_opcode == cgkl_pkg::OP_APPEND &&
            r_key_count < cgkl_pkg::CNT_W'(cgkl_pkg::MAX_KEYS)) begin
            r_table[r_key_count[cgkl_pkg::IDX_W-1:0]] <=
                {i_position, i_key_red, i_key_green, i_key_blue};
        end
    end

    // Scan, weights, multiply, divide, result.
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_pos     <= (i_position > cgkl_pkg::POS_ONE) ? cgkl_pkg::POS_ONE : i_position;
            r_idx     <= '0;
            r_have_lo <= 1'b0;
            r_have_hi <= 1'b0;
            r_ch      <= 2'd0;
            r_res[0]  <= '0;
            r_res[1]  <= '0;
            r_res[2]  <= '0;
            unique case (i_opcode)
                cgkl_pkg::OP_APPEND:
                    r_res_st <= (r_key_count < cgkl_pkg::CNT_W'(cgkl_pkg::MAX_KEYS)) ?
                                cgkl_pkg::ST_OK : cgkl_pkg::ST_FULL;
                cgkl_pkg::OP_SAMPLE:
                    r_res_st <= bounds_valid ? cgkl_pkg::ST_OK : cgkl_pkg::ST_MALFORMED;
                default: r_res_st <= cgkl_pkg::ST_OK;
            endcase
        end
        if (i_cmd.scan) begin
            r_idx <= r_idx + 1'b1;
            if (ent_p == r_pos) begin
                r_res[0] <= ent[47:32];
                r_res[1] <= ent[31:16];
                r_res[2] <= ent[15:0];
            end
            if (ent_p < r_pos && (!r_have_lo || ent_p > r_lo_p)) begin
                r_have_lo <= 1'b1;
                r_lo_p    <= ent_p;
                r_lo_col  <= ent[47:0];
            end
            if (ent_p > r_pos && (!r_have_hi || ent_p < r_hi_p)) begin
                r_have_hi <= 1'b1;
                r_hi_p    <= ent_p;
                r_hi_col  <= ent[47:0];
            end
        end
        if (i_cmd.setup) begin
            r_wl   <= r_hi_p - r_pos;
            r_wh   <= r_pos - r_lo_p;
            r_span <= r_hi_p - r_lo_p;
        end
        if (i_cmd.mul) begin
            r_p0 <= cl * r_wl;
            r_p1 <= ch * r_wh;
        end
        if (i_cmd.div_init) begin
            r_rem     <= psum[31:16];
            r_dq      <= psum[15:0];
            r_div_cnt <= '0;
        end
        if (i_cmd.div_step) begin
            r_rem     <= rem_next;
            r_dq      <= q_next;
            r_div_cnt <= r_div_cnt + 1'b1;
            if (r_div_cnt == 4'(cgkl_pkg::DIV_W - 1)) begin
                r_res[r_ch] <= q_next;
                r_ch        <= r_ch + 1'b1;
            end
        end
        if (i_cmd.out_load) begin
            o_out_red    <= r_res[0];
            o_out_green  <= r_res[1];
            o_out_blue   <= r_res[2];
            o_out_status <= r_res_st;
        end
    end

endmodule

FILE: design/color_gradient_keyframe_lerp_core.sv
// Color ramp keyframe interpolation, top level: controller plus datapath.
// Clear, append and malformed sample go straight to the result register;
// a sample scans the keys and, with no exact match and both neighbours
// found, runs one 16-step serial divide per channel. One item at a time;
// the next item is taken once the result is in the output register.
// Reset (synchronous, active low) empties the table; table entries hold.
module color_gradient_keyframe_lerp_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_opcode,
    input  logic [15:0] i_position,
    input  logic [15:0] i_key_red,
    input  logic [15:0] i_key_green,
    input  logic [15:0] i_key_blue,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [15:0] o_out_red,
    output logic [15:0] o_out_green,
    output logic [15:0] o_out_blue,
    output logic [1:0]  o_out_status
);

    cgkl_pkg::t_cmd cmd;
    cgkl_pkg::t_sts sts;

    // Sequence each sample through scan, weight setup and per-channel divide.
    cgkl_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_out_stall (i_out_stall),
        .i_sts       (sts),
        .o_cmd       (cmd),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid)
    );

    // Hold the table and do the arithmetic.
    cgkl_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .i_opcode     (i_opcode),
        .i_position   (i_position),
        .i_key_red    (i_key_red),
        .i_key_green  (i_key_green),
        .i_key_blue   (i_key_blue),
        .o_sts        (sts),
        .o_out_red    (o_out_red),
        .o_out_green  (o_out_green),
        .o_out_blue   (o_out_blue),
        .o_out_status (o_out_status)
    );

`ifndef ASSERT_OFF
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("item accepted but block not busy");

    a_malformed_black: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_status == cgkl_pkg::ST_MALFORMED |->
        o_out_red == 16'd0 && o_out_green == 16'd0 && o_out_blue == 16'd0)
        else $error("malformed result carries color");

    a_full_black: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_status == cgkl_pkg::ST_FULL |->
        o_out_red == 16'd0 && o_out_green == 16'd0 && o_out_blue == 16'd0)
        else $error("dropped append carries color");
`endif

endmodule
